// File: rtl/dpi_edge_prune_query_top_defines.svh
// assertion macros for the pair-pruning query block
// used by the port checker, no other dependencies
`ifndef DPI_EDGE_PRUNE_QUERY_TOP_DEFINES_SVH
`define DPI_EDGE_PRUNE_QUERY_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define DPQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dpq port check failed");

// next-cycle implication, disabled during reset
`define DPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dpq port check failed");

`endif

// File: rtl/dpq_pkg.sv
// shared types and constants for the pair-pruning query block
// no dependencies
package dpq_pkg;

    // field widths
    localparam int GENE_W    = 6;
    localparam int VAL_W     = 20;
    localparam int TOL_W     = 21;
    localparam int CNT_W     = 7;
    localparam int CFG_W     = 21;
    localparam int CFG_IDX_W = 2;

    // default matrix size
    localparam int MAX_GENES_DEF = 64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GENE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE  = 2'd2;

    // reset values
    localparam logic [CNT_W-1:0] GENE_COUNT_RST = 7'd64;

    // request codes
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD2,
        ST_FETCH,
        ST_SEED,
        ST_SCAN,
        ST_DONE
    } t_state;

endpackage

// File: rtl/dpi_edge_prune_query_top.sv
// top level of the pair-pruning query block: sequencer, two matrix copies
// and result register; depends on dpq_pkg
//
// Input channel (i_in_valid / o_in_stall) carries load and query beats.
// A load writes the pair value into both orientations of a symmetric
// matrix held twice in block memory, (a,b) on accept, (b,a) in ST_LOAD2;
// it gives no result. A query reads the pair value, checks it against
// the threshold, then walks every gene k, reading (a,k) from one copy
// and (b,k) from the other in the same cycle. One k per cycle, for k
// below n, n being the active gene count. A query on the diagonal or out
// of range goes straight to ST_DONE; one at or below the threshold ends
// after the seed read, with no scan.
// The block handles one beat at a time; the result sits in an output
// register, so the next beat is taken while o_out_valid waits under
// i_out_stall. A stalled result holds until taken.
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data by
// the user only while idle, not enforced by the block. Reset clears the
// sequencer, output valid and config registers; matrix undefined till loaded.
module dpi_edge_prune_query_top #(
    parameter int MAX_GENES = dpq_pkg::MAX_GENES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration port
    input  logic                           i_cfg_we,
    input  logic [dpq_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dpq_pkg::CFG_W-1:0]      i_cfg_data,
    // input channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_req_type,
    input  logic [dpq_pkg::GENE_W-1:0]     i_gene_a,
    input  logic [dpq_pkg::GENE_W-1:0]     i_gene_b,
    input  logic [dpq_pkg::VAL_W-1:0]      i_mi_value,
    // output channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_kept,
    output logic                           o_query_valid
);
    import dpq_pkg::*;

    localparam int IW    = $clog2(MAX_GENES);
    localparam int AW    = 2 * IW;
    localparam int DEPTH = 1 << AW;
    localparam int KW0   = $clog2(MAX_GENES + 1);
    localparam int CW    = (KW0 > CNT_W) ? KW0 : CNT_W;
    localparam int SW    = VAL_W + 2;

    // configuration registers
    logic [CNT_W-1:0]        r_gene_count;
    logic [VAL_W-1:0]        r_thr;
    logic signed [TOL_W-1:0] r_tol;

    // sequencer
    t_state r_state, n_state;

    // beat registers
    logic [GENE_W-1:0] r_a, r_b;
    logic [VAL_W-1:0]  r_val;
    logic              r_ld_ok;
    logic              r_res_kept, r_res_qv;

    // scan registers
    logic [CW-1:0]        r_k;
    logic                 r_chk;
    logic                 r_pruned;
    logic signed [SW-1:0] r_lhs;

    // matrix copies and read data
    logic [VAL_W-1:0] mem0 [DEPTH];
    logic [VAL_W-1:0] mem1 [DEPTH];
    logic [VAL_W-1:0] r_rd0, r_rd1;

    // output register
    logic r_out_valid, r_kept, r_qv;

    // memory port controls
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [VAL_W-1:0] wr_data;
    logic [AW-1:0]    rd_addr0, rd_addr1;

    // derived control
    logic                 in_acc, out_free;
    logic [CW-1:0]        n_eff, gc_ext, max_c;
    logic                 q_ok, ld_ok_in;
    logic                 seed_ok, issue, hit;
    logic signed [SW-1:0] lhs;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gene_count <= GENE_COUNT_RST;
            r_thr        <= '0;
            r_tol        <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GENE_COUNT: r_gene_count <= i_cfg_data[CNT_W-1:0];
                CFG_THRESHOLD:  r_thr        <= i_cfg_data[VAL_W-1:0];
                CFG_TOLERANCE:  r_tol        <= $signed(i_cfg_data[TOL_W-1:0]);
                default: ;
            endcase
        end
    end

    // effective gene count and index checks
    assign gc_ext   = CW'(r_gene_count);
    assign max_c    = CW'(MAX_GENES);
    assign n_eff    = (gc_ext < max_c) ? gc_ext : max_c;
    assign q_ok     = (i_gene_a != i_gene_b) && (CW'(i_gene_a) < n_eff)
                      && (CW'(i_gene_b) < n_eff);
    assign ld_ok_in = (CW'(i_gene_a) < max_c) && (CW'(i_gene_b) < max_c);

    // handshakes
    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // seed and scan tests
    assign seed_ok = r_rd0 > r_thr;
    assign lhs     = $signed({2'b00, r_rd0}) + SW'(r_tol);
    assign issue   = r_k < n_eff;
    assign hit     = r_chk && (r_lhs < $signed({2'b00, r_rd0}))
                     && (r_lhs < $signed({2'b00, r_rd1}));

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_req_type == REQ_LOAD) n_state = ST_LOAD2;
                    else if (q_ok)              n_state = ST_FETCH;
                    else                        n_state = ST_DONE;
                end
            end
            ST_LOAD2: n_state = ST_IDLE;
            ST_FETCH: n_state = ST_SEED;
            ST_SEED:  n_state = seed_ok ? ST_SCAN : ST_DONE;
            ST_SCAN:  n_state = issue ? ST_SCAN : ST_DONE;
            ST_DONE:  n_state = out_free ? ST_IDLE : ST_DONE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs: stall and memory ports
    always_comb begin
        o_in_stall = (r_state != ST_IDLE);
        wr_en      = (in_acc && (i_req_type == REQ_LOAD) && ld_ok_in)
                     || ((r_state == ST_LOAD2) && r_ld_ok);
        if (r_state == ST_LOAD2) begin
            wr_addr = {IW'(r_b), IW'(r_a)};
            wr_data = r_val;
        end else begin
            wr_addr = {IW'(i_gene_a), IW'(i_gene_b)};
            wr_data = i_mi_value;
        end
        if (r_state == ST_FETCH) rd_addr0 = {IW'(r_a), IW'(r_b)};
        else                     rd_addr0 = {IW'(r_a), r_k[IW-1:0]};
        rd_addr1 = {IW'(r_b), r_k[IW-1:0]};
    end

    // matrix copies, identical contents, one read port each
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem0[wr_addr] <= wr_data;
            mem1[wr_addr] <= wr_data;
        end
        r_rd0 <= mem0[rd_addr0];
        r_rd1 <= mem1[rd_addr1];
    end

    // beat capture and scan datapath
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a        <= i_gene_a;
            r_b        <= i_gene_b;
            r_val      <= i_mi_value;
            r_ld_ok    <= ld_ok_in;
            r_res_qv   <= q_ok;
            r_res_kept <= 1'b0;
        end
        if (r_state == ST_SEED) begin
            r_lhs    <= lhs;
            r_k      <= '0;
            r_chk    <= 1'b0;
            r_pruned <= 1'b0;
        end
        if (r_state == ST_SCAN) begin
            r_k      <= issue ? r_k + CW'(1) : r_k;
            r_chk    <= issue && (r_k != CW'(r_a)) && (r_k != CW'(r_b));
            r_pruned <= r_pruned | hit;
            if (!issue) r_res_kept <= !(r_pruned | hit);
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_DONE) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_DONE) && out_free) begin
            r_kept <= r_res_kept;
            r_qv   <= r_res_qv;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kept        = r_kept;
    assign o_query_valid = r_qv;

endmodule

// File: rtl/dpq_checker.sv
// port-level checker for the pair-pruning query block and its bind
// depends on dpi_edge_prune_query_top_defines.svh
`include "dpi_edge_prune_query_top_defines.svh"

module dpq_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input logic o_kept,
    input logic o_query_valid
);
    // a stalled result beat holds its value
    `DPQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_kept) && $stable(o_query_valid))

    // a kept edge is always a valid query
    `DPQ_ASSERT_NOW(a_kept_valid, i_clk, i_rst_n, o_out_valid && o_kept, o_query_valid)

    // every accepted beat makes the block busy in the cycle after it
    `DPQ_ASSERT_NEXT(a_busy_after_beat, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

endmodule

bind dpi_edge_prune_query_top dpq_checker u_dpq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_kept        (o_kept),
    .o_query_valid (o_query_valid)
);
